FILE: rtl/crossing_band_classifier_top_defines.svh
// Assertion macros for the crossing band classifier RTL.
// Define NO_ASSERTIONS to compile every use of these macros to nothing.
`ifndef CROSSING_BAND_CLASSIFIER_TOP_DEFINES_SVH
`define CROSSING_BAND_CLASSIFIER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define CBC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("crossing band classifier: invariant violated");

// The consequence holds in the same cycle as the antecedent.
`define CBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crossing band classifier: implication violated");

// The consequence holds in the cycle after the antecedent.
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crossing band classifier: next-cycle check violated");

`else

`define CBC_ASSERT_ALWAYS(label, clk, rst, expr)
`define CBC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/cbc_pkg.sv
`default_nettype none

package cbc_pkg;

   // Field widths.
   localparam int MIC_W      = 10;
   localparam int CUR_W      = 10;
   localparam int CROSS_W    = 13;
   localparam int SUM_W      = 22;
   localparam int PAIR_W     = 13;
   localparam int LOG2_W     = 4;
   localparam int THRESH_W   = 8;
   localparam int REPEAT_W   = 4;
   localparam int MEAN_W     = 10;
   localparam int BAND_W     = 3;
   localparam int STEP_W     = 2;
   localparam int SAT8_W     = 8;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIC_MIDPOINT         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LOG2          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_THRESHOLD       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRESS_CURRENT_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRESS_REPEAT        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_NEEDED         = 3'd5;

   localparam logic [MIC_W-1:0]    RST_MIC_MIDPOINT         = 10'd512;
   localparam logic [LOG2_W-1:0]   RST_WINDOW_LOG2          = 4'd9;
   localparam logic [THRESH_W-1:0] RST_BAND_THRESHOLD       = 8'd25;
   localparam logic [MEAN_W-1:0]   RST_STRESS_CURRENT_LIMIT = 10'd10;
   localparam logic [REPEAT_W-1:0] RST_STRESS_REPEAT        = 4'd2;
   localparam logic [REPEAT_W-1:0] RST_MATCH_NEEDED         = 4'd2;

   // Input beat kinds.
   localparam logic MODE_PRIME = 1'b0;
   localparam logic MODE_PAIR  = 1'b1;

   // Limits.
   localparam logic [LOG2_W-1:0]  MAX_LOG2  = 4'd12;
   localparam logic [CROSS_W-1:0] CROSS_MAX = {CROSS_W{1'b1}};
   localparam logic [PAIR_W-1:0]  PAIR_MAX  = {PAIR_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [SAT8_W-1:0]  SAT8_MAX  = {SAT8_W{1'b1}};

   // Band codes, of which 6 and 7 block stress moves, and the last stress step.
   localparam logic [BAND_W-1:0] BAND_HOT_LO = 3'd6;
   localparam logic [BAND_W-1:0] BAND_HOT_HI = 3'd7;
   localparam logic [BAND_W-1:0] BAND_TOP    = 3'd7;
   localparam logic [BAND_W-1:0] BAND_ZERO   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LAST   = 2'd2;

   // Window record queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [MIC_W-1:0]    mic_midpoint;
      logic [LOG2_W-1:0]   window_log2;
      logic [THRESH_W-1:0] band_threshold;
      logic [MEAN_W-1:0]   stress_current_limit;
      logic [REPEAT_W-1:0] stress_repeat;
      logic [REPEAT_W-1:0] match_needed;
   } cfg_type;

   // One finished window, handed from the front to the back.
   typedef struct packed {
      logic [CROSS_W-1:0] crossings;
      logic [SUM_W-1:0]   current_sum;
   } win_type;

   typedef struct packed {
      logic              full;
      logic              not_empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   // Window size exponent, clamped to the largest legal window.
   function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] wl);
      return (wl > MAX_LOG2) ? MAX_LOG2 : wl;
   endfunction

   // Band of a crossing count: 0 below 2T, k-1 below kT for k = 3..7, else 7.
   function automatic logic [BAND_W-1:0] classify(input logic [CROSS_W-1:0] n,
                                                  input logic [THRESH_W-1:0] t);
      logic [CROSS_W-1:0] lim;
      logic [BAND_W-1:0]  band;
      band = BAND_TOP;
      for (int k = 7; k >= 3; k--) begin
         lim = CROSS_W'(t) * CROSS_W'(k);
         if (n < lim) begin
            band = BAND_W'(k - 1);
         end
      end
      lim = CROSS_W'(t) * CROSS_W'(2);
      if (n < lim) begin
         band = BAND_ZERO;
      end
      return band;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/crossing_band_classifier_top.sv
`default_nettype none

`include "crossing_band_classifier_top_defines.svh"

// Crossing band classifier. Each request beat is either a priming beat (mode 0),
// which only loads the previous microphone sample, or a measurement pair (mode 1).
// Pairs are gathered in windows of 2^window_log2 (clamped to 4096); within a window
// the block counts crossings of the microphone signal over mic_midpoint and sums the
// motor current. When a window closes, its crossing count and current sum go into a
// two-entry queue, and the back end turns them into at most one response beat: a
// stress step (0, 1, 2 in turn) once enough windows in a row have a mean current at
// or above stress_current_limit and the last band is not 6 or 7, or else a band
// (0, 2..7, in steps of band_threshold) once it has repeated match_needed times.
// The block takes one request beat per clock; req_stall rises only while the window
// queue is full, which happens only when response beats are held back by rsp_stall.
// A closing window is written into the queue, and the back end registers any response
// from the queue head; a response held by rsp_stall delays this. The back end takes a
// new window whenever no response is held, so windows of any size keep the full rate.
// Configuration registers are written through the csr_ port with csr_write high
// and must only be changed while no window is pending in the block.
module crossing_band_classifier_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration write port.
   input  wire logic                              csr_write,
   input  wire logic [cbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cbc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Request channel.
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [cbc_pkg::MIC_W-1:0]         req_mic_sample,
   input  wire logic [cbc_pkg::CUR_W-1:0]         req_current_sample,
   // Response channel.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [cbc_pkg::BAND_W-1:0]             rsp_pattern,
   output logic                                   rsp_from_stress,
   output logic [cbc_pkg::CROSS_W-1:0]            rsp_crossings,
   output logic [cbc_pkg::MEAN_W-1:0]             rsp_mean_current
);
   import cbc_pkg::*;

   // Configuration registers, reset to their documented defaults.
   logic [MIC_W-1:0]    mic_midpoint_ff;
   logic [LOG2_W-1:0]   window_log2_ff;
   logic [THRESH_W-1:0] band_threshold_ff;
   logic [MEAN_W-1:0]   stress_current_limit_ff;
   logic [REPEAT_W-1:0] stress_repeat_ff;
   logic [REPEAT_W-1:0] match_needed_ff;
   cfg_type             cfg;

   // Front to queue to back.
   logic                push;
   win_type             push_data;
   logic                pop;
   win_type             head;
   queue_status_type    q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mic_midpoint_ff         <= RST_MIC_MIDPOINT;
         window_log2_ff          <= RST_WINDOW_LOG2;
         band_threshold_ff       <= RST_BAND_THRESHOLD;
         stress_current_limit_ff <= RST_STRESS_CURRENT_LIMIT;
         stress_repeat_ff        <= RST_STRESS_REPEAT;
         match_needed_ff         <= RST_MATCH_NEEDED;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MIC_MIDPOINT: begin
               mic_midpoint_ff <= csr_wdata[MIC_W-1:0];
            end
            CSR_WINDOW_LOG2: begin
               window_log2_ff <= csr_wdata[LOG2_W-1:0];
            end
            CSR_BAND_THRESHOLD: begin
               band_threshold_ff <= csr_wdata[THRESH_W-1:0];
            end
            CSR_STRESS_CURRENT_LIMIT: begin
               stress_current_limit_ff <= csr_wdata[MEAN_W-1:0];
            end
            CSR_STRESS_REPEAT: begin
               stress_repeat_ff <= csr_wdata[REPEAT_W-1:0];
            end
            CSR_MATCH_NEEDED: begin
               match_needed_ff <= csr_wdata[REPEAT_W-1:0];
            end
            default: begin
               // Indexes past the register list are ignored.
            end
         endcase
      end
   end

   assign cfg.mic_midpoint         = mic_midpoint_ff;
   assign cfg.window_log2          = window_log2_ff;
   assign cfg.band_threshold       = band_threshold_ff;
   assign cfg.stress_current_limit = stress_current_limit_ff;
   assign cfg.stress_repeat        = stress_repeat_ff;
   assign cfg.match_needed         = match_needed_ff;

   // The front end accumulates each window and closes it into the queue.
   cbc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_mic_sample     (req_mic_sample),
      .req_current_sample (req_current_sample),
      .q_status           (q_status),
      .push               (push),
      .push_data          (push_data)
   );

   // The queue lets the front keep taking beats while a response is held.
   cbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // The back end runs the stress and band decisions and owns the response register.
   cbc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head             (head),
      .head_valid       (q_status.not_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pattern      (rsp_pattern),
      .rsp_from_stress  (rsp_from_stress),
      .rsp_crossings    (rsp_crossings),
      .rsp_mean_current (rsp_mean_current)
   );

   // The queue never holds more records than it has entries.
   `CBC_ASSERT_ALWAYS(a_queue_bound, clock, reset, q_status.count <= QCNT_W'(QUEUE_DEPTH))
   // A window record is never pushed into a full queue.
   `CBC_ASSERT_IMPLY(a_no_overflow, clock, reset, q_status.full, !push)
   // Without a popped window and with no held response, the next cycle shows no beat.
   `CBC_ASSERT_NEXT(a_rsp_from_pop, clock, reset, !pop && !(rsp_valid && rsp_stall), !rsp_valid)
   // Stress steps only run 0 to 2.
   `CBC_ASSERT_IMPLY(a_stress_range, clock, reset, rsp_valid && rsp_from_stress, rsp_pattern <= BAND_W'(STEP_LAST))

endmodule

`default_nettype wire

FILE: rtl/cbc_front.sv
`default_nettype none

module cbc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cbc_pkg::cfg_type            cfg,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_mode,
   input  wire logic [cbc_pkg::MIC_W-1:0]   req_mic_sample,
   input  wire logic [cbc_pkg::CUR_W-1:0]   req_current_sample,
   input  wire cbc_pkg::queue_status_type   q_status,
   output logic                             push,
   output cbc_pkg::win_type                 push_data
);
   import cbc_pkg::*;

   logic [MIC_W-1:0]   prev_mic_ff, prev_mic_in;
   logic [CROSS_W-1:0] cross_ff, cross_in, cross_next;
   logic [SUM_W-1:0]   sum_ff, sum_in, sum_next;
   logic [PAIR_W-1:0]  pair_ff, pair_in, pair_next;
   logic [SUM_W:0]     sum_wide;
   logic [PAIR_W-1:0]  window_len;
   logic               accept;
   logic               crossed;
   logic               win_end;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   assign crossed    = (req_mic_sample > cfg.mic_midpoint) != (prev_mic_ff > cfg.mic_midpoint);
   assign cross_next = (crossed && cross_ff != CROSS_MAX) ? cross_ff + 1'b1 : cross_ff;
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(req_current_sample);
   assign sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign pair_next  = (pair_ff != PAIR_MAX) ? pair_ff + 1'b1 : pair_ff;
   assign window_len = PAIR_W'(1) << eff_log2(cfg.window_log2);
   assign win_end    = pair_next >= window_len;

   assign push_data.crossings   = cross_next;
   assign push_data.current_sum = sum_next;

   always_comb begin
      prev_mic_in = prev_mic_ff;
      cross_in    = cross_ff;
      sum_in      = sum_ff;
      pair_in     = pair_ff;
      push        = 1'b0;
      if (accept) begin
         prev_mic_in = req_mic_sample;
         if (req_mode == MODE_PAIR) begin
            if (win_end) begin
               push     = 1'b1;
               cross_in = '0;
               sum_in   = '0;
               pair_in  = '0;
            end else begin
               cross_in = cross_next;
               sum_in   = sum_next;
               pair_in  = pair_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mic_ff <= '0;
         cross_ff    <= '0;
         sum_ff      <= '0;
         pair_ff     <= '0;
      end else begin
         prev_mic_ff <= prev_mic_in;
         cross_ff    <= cross_in;
         sum_ff      <= sum_in;
         pair_ff     <= pair_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cbc_queue.sv
`default_nettype none

module cbc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire cbc_pkg::win_type          push_data,
   input  wire logic                      pop,
   output cbc_pkg::win_type               head,
   output cbc_pkg::queue_status_type      status
);
   import cbc_pkg::*;

   win_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;
   assign head             = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cbc_back.sv
`default_nettype none

module cbc_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cbc_pkg::cfg_type             cfg,
   input  wire cbc_pkg::win_type             head,
   input  wire logic                         head_valid,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [cbc_pkg::BAND_W-1:0]        rsp_pattern,
   output logic                              rsp_from_stress,
   output logic [cbc_pkg::CROSS_W-1:0]       rsp_crossings,
   output logic [cbc_pkg::MEAN_W-1:0]        rsp_mean_current
);
   import cbc_pkg::*;

   logic [SAT8_W-1:0]  stress_windows_ff, stress_windows_in;
   logic [STEP_W-1:0]  stress_step_ff, stress_step_in;
   logic [BAND_W-1:0]  last_band_ff, last_band_in;
   logic [SAT8_W-1:0]  agree_ff, agree_in;
   logic               rsp_valid_ff;
   logic [BAND_W-1:0]  pattern_ff, pattern_in;
   logic               from_stress_ff, from_stress_in;
   logic [CROSS_W-1:0] crossings_ff;
   logic [MEAN_W-1:0]  mean_ff;

   logic [SUM_W-1:0]   shifted;
   logic [MEAN_W-1:0]  mean;
   logic               hot_band;
   logic               stressed;
   logic [BAND_W-1:0]  band;
   logic               emit;

   assign pop      = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign shifted  = head.current_sum >> eff_log2(cfg.window_log2);
   assign mean     = shifted[MEAN_W-1:0];
   assign hot_band = (last_band_ff == BAND_HOT_LO) || (last_band_ff == BAND_HOT_HI);
   assign stressed = (mean >= cfg.stress_current_limit);
   assign band     = classify(head.crossings, cfg.band_threshold);

   always_comb begin
      stress_windows_in = stress_windows_ff;
      stress_step_in    = stress_step_ff;
      last_band_in      = last_band_ff;
      agree_in          = agree_ff;
      pattern_in        = pattern_ff;
      from_stress_in    = from_stress_ff;
      emit              = 1'b0;
      if (pop) begin
         if (!stressed) begin
            stress_windows_in = '0;
         end else if (stress_windows_ff != SAT8_MAX) begin
            stress_windows_in = stress_windows_ff + 1'b1;
         end

         if (stressed && stress_windows_in >= SAT8_W'(cfg.stress_repeat) && !hot_band) begin
            stress_step_in = (stress_step_ff >= STEP_LAST) ? '0 : stress_step_ff + 1'b1;
            pattern_in     = BAND_W'(stress_step_in);
            from_stress_in = 1'b1;
            emit           = 1'b1;
         end

         // The band path runs only when the stress path cannot emit.
         if (stress_windows_in < SAT8_W'(cfg.stress_repeat) || hot_band) begin
            if (band != last_band_ff) begin
               last_band_in = band;
               agree_in     = '0;
            end else begin
               if (agree_ff != SAT8_MAX) begin
                  agree_in = agree_ff + 1'b1;
               end
               if (agree_in >= SAT8_W'(cfg.match_needed)) begin
                  pattern_in     = band;
                  from_stress_in = 1'b0;
                  emit           = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         pattern_ff     <= pattern_in;
         from_stress_ff <= from_stress_in;
         crossings_ff   <= head.crossings;
         mean_ff        <= mean;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stress_windows_ff <= '0;
         stress_step_ff    <= '0;
         last_band_ff      <= '0;
         agree_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         stress_windows_ff <= stress_windows_in;
         stress_step_ff    <= stress_step_in;
         last_band_ff      <= last_band_in;
         agree_ff          <= agree_in;
         if (pop && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern      = pattern_ff;
   assign rsp_from_stress  = from_stress_ff;
   assign rsp_crossings    = crossings_ff;
   assign rsp_mean_current = mean_ff;

endmodule

`default_nettype wire
